// ----- hdl/poly_voice_allocator_unit_defines.svh -----
`ifndef POLY_VOICE_ALLOCATOR_UNIT_DEFINES_SVH
`define POLY_VOICE_ALLOCATOR_UNIT_DEFINES_SVH

// Checks that hold in the same cycle.
`define PVA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that hold in the next cycle.
`define PVA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/pva_pkg.sv -----
`default_nettype none

package pva_pkg;

   localparam int KEY_W    = 4;
   localparam int DONE_W   = 3;
   localparam int VIDX_OUT_W = 3;
   localparam int STAMP_W  = 32;
   localparam int COUNT_W  = 4;
   localparam int MAP_W    = 16;

   localparam logic [1:0] KIND_ON   = 2'd0;
   localparam logic [1:0] KIND_OFF  = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   localparam logic [2:0] ACT_NONE     = 3'd0;
   localparam logic [2:0] ACT_RETRIG   = 3'd1;
   localparam logic [2:0] ACT_FREE     = 3'd2;
   localparam logic [2:0] ACT_STOLEN   = 3'd3;
   localparam logic [2:0] ACT_GATE_OFF = 3'd4;
   localparam logic [2:0] ACT_FREED    = 3'd5;

   typedef struct packed {
      logic capture;
      logic scan;
      logic apply;
   } ctrl_cmd_type;

   typedef struct packed {
      logic needs_scan;
      logic scan_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- hdl/poly_voice_allocator_unit.sv -----
`default_nettype none

// Voice allocator for a pool of NUM_VOICES voices. An item is taken when start is
// high and busy low; its result appears on the rsp_ ports for one cycle with
// rsp_valid high and cannot be held off, so it must be captured then. Note-on and
// note-off items walk the voice table one voice per cycle in the scan state
// before the apply state; voice-done items need no walk and go straight to
// the apply state. The result strobe is high in the first cycle with busy
// low, and a new item may be started in that same cycle.

`include "poly_voice_allocator_unit_defines.svh"

module poly_voice_allocator_unit #(
   parameter int NUM_VOICES = 8,
   parameter int NUM_KEYS   = 16,
   parameter int AGE_BITS   = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_kind,
   input  wire logic [pva_pkg::KEY_W-1:0]        req_key,
   input  wire logic [pva_pkg::DONE_W-1:0]       req_done_voice,
   output logic                                  rsp_valid,
   output logic [pva_pkg::VIDX_OUT_W-1:0]        rsp_voice_index,
   output logic [2:0]                            rsp_action,
   output logic [pva_pkg::STAMP_W-1:0]           rsp_note_stamp,
   output logic [pva_pkg::COUNT_W-1:0]           rsp_active_count,
   output logic [pva_pkg::MAP_W-1:0]             rsp_key_active_map
);

   pva_pkg::ctrl_cmd_type  cmd;
   pva_pkg::dp_status_type status;

   pva_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   pva_datapath #(
      .NUM_VOICES (NUM_VOICES),
      .NUM_KEYS   (NUM_KEYS),
      .AGE_BITS   (AGE_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_kind           (req_kind),
      .req_key            (req_key),
      .req_done_voice     (req_done_voice),
      .rsp_valid          (rsp_valid),
      .rsp_voice_index    (rsp_voice_index),
      .rsp_action         (rsp_action),
      .rsp_note_stamp     (rsp_note_stamp),
      .rsp_active_count   (rsp_active_count),
      .rsp_key_active_map (rsp_key_active_map)
   );

   `PVA_ASSERT_IMP(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "result shown while busy")
   `PVA_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe too long")
   `PVA_ASSERT_IMP(a_none_is_zero, clock, reset, rsp_valid && (rsp_action == pva_pkg::ACT_NONE), (rsp_voice_index == '0) && (rsp_note_stamp == '0), "no-op item reports a voice or stamp")
   `PVA_ASSERT_IMP(a_steal_full, clock, reset, rsp_valid && (rsp_action == pva_pkg::ACT_STOLEN), rsp_active_count == pva_pkg::COUNT_W'(NUM_VOICES), "steal with voices idle")

endmodule

`default_nettype wire

// ----- hdl/pva_ctrl.sv -----
`default_nettype none

module pva_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire pva_pkg::dp_status_type status,
   output pva_pkg::ctrl_cmd_type       cmd,
   output logic                        busy
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = status.needs_scan ? ST_SCAN : ST_APPLY;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.capture = (state_ff == ST_IDLE) && start;
   assign cmd.scan    = (state_ff == ST_SCAN);
   assign cmd.apply   = (state_ff == ST_APPLY);
   assign busy        = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ----- hdl/pva_datapath.sv -----
`default_nettype none

module pva_datapath #(
   parameter int NUM_VOICES = 8,
   parameter int NUM_KEYS   = 16,
   parameter int AGE_BITS   = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire pva_pkg::ctrl_cmd_type            cmd,
   output pva_pkg::dp_status_type                status,
   input  wire logic [1:0]                       req_kind,
   input  wire logic [pva_pkg::KEY_W-1:0]        req_key,
   input  wire logic [pva_pkg::DONE_W-1:0]       req_done_voice,
   output logic                                  rsp_valid,
   output logic [pva_pkg::VIDX_OUT_W-1:0]        rsp_voice_index,
   output logic [2:0]                            rsp_action,
   output logic [pva_pkg::STAMP_W-1:0]           rsp_note_stamp,
   output logic [pva_pkg::COUNT_W-1:0]           rsp_active_count,
   output logic [pva_pkg::MAP_W-1:0]             rsp_key_active_map
);

   localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CNT_W  = $clog2(NUM_VOICES + 1);
   localparam int KEY_W  = pva_pkg::KEY_W;

   // item
   logic [1:0]        kind_ff, kind_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              done_ok_ff, done_ok_in;

   // scan
   logic [VIDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic                hit_ff, hit_in;
   logic [VIDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic                idle_ff, idle_in;
   logic [VIDX_W-1:0]   idle_idx_ff, idle_idx_in;
   logic [VIDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [AGE_BITS-1:0] best_age_ff, best_age_in;
   logic [KEY_W-1:0]    best_key_ff, best_key_in;

   // voice state
   logic [NUM_VOICES-1:0] active_ff, active_in;
   logic [NUM_VOICES-1:0] gate_ff, gate_in;
   logic [KEY_W-1:0]      vkey_ff [NUM_VOICES];
   logic [KEY_W-1:0]      vkey_in [NUM_VOICES];
   logic [AGE_BITS-1:0]   age_ff [NUM_VOICES];
   logic [AGE_BITS-1:0]   age_in [NUM_VOICES];
   logic [AGE_BITS-1:0]   note_count_ff, note_count_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [pva_pkg::MAP_W-1:0] map_ff, map_in;

   // result
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pva_pkg::VIDX_OUT_W-1:0]    rsp_vidx_ff, rsp_vidx_in;
   logic [2:0]                        rsp_action_ff, rsp_action_in;
   logic [pva_pkg::STAMP_W-1:0]       rsp_stamp_ff, rsp_stamp_in;
   logic [pva_pkg::COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic [pva_pkg::MAP_W-1:0]         rsp_map_ff, rsp_map_in;

   logic                rd_active;
   logic                rd_gate;
   logic [KEY_W-1:0]    rd_key;
   logic [AGE_BITS-1:0] rd_age;
   logic                scan_last;
   logic                on_ok;
   logic                off_ok;
   logic [AGE_BITS-1:0] note_nxt;
   logic [VIDX_W-1:0]   sel;
   logic [2:0]          act;

   assign rd_active = active_ff[scan_idx_ff];
   assign rd_gate   = gate_ff[scan_idx_ff];
   assign rd_key    = vkey_ff[scan_idx_ff];
   assign rd_age    = age_ff[scan_idx_ff];
   assign scan_last = (scan_idx_ff == VIDX_W'(NUM_VOICES - 1));
   assign on_ok     = (kind_ff == pva_pkg::KIND_ON) && (32'(key_ff) < 32'(NUM_KEYS));
   assign off_ok    = (kind_ff == pva_pkg::KIND_OFF) && (32'(key_ff) < 32'(NUM_KEYS));
   assign note_nxt  = note_count_ff + AGE_BITS'(1);

   assign status.scan_last  = scan_last;
   assign status.needs_scan = (req_kind == pva_pkg::KIND_ON) || (req_kind == pva_pkg::KIND_OFF);

   always_comb begin
      kind_in       = kind_ff;
      key_in        = key_ff;
      done_ok_in    = done_ok_ff;
      scan_idx_in   = scan_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      idle_in       = idle_ff;
      idle_idx_in   = idle_idx_ff;
      best_idx_in   = best_idx_ff;
      best_age_in   = best_age_ff;
      best_key_in   = best_key_ff;
      active_in     = active_ff;
      gate_in       = gate_ff;
      vkey_in       = vkey_ff;
      age_in        = age_ff;
      note_count_in = note_count_ff;
      count_in      = count_ff;
      map_in        = map_ff;
      rsp_valid_in  = cmd.apply;
      rsp_vidx_in   = rsp_vidx_ff;
      rsp_action_in = rsp_action_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_map_in    = rsp_map_ff;
      sel           = '0;
      act           = pva_pkg::ACT_NONE;

      if (cmd.capture) begin
         kind_in     = req_kind;
         key_in      = req_key;
         done_ok_in  = 32'(req_done_voice) < 32'(NUM_VOICES);
         scan_idx_in = ((req_kind == pva_pkg::KIND_DONE) &&
                        (32'(req_done_voice) < 32'(NUM_VOICES))) ?
                       VIDX_W'(req_done_voice) : '0;
         hit_in      = 1'b0;
         idle_in     = 1'b0;
      end

      if (cmd.scan) begin
         if (!hit_ff && rd_active && (rd_key == key_ff)) begin
            hit_in     = 1'b1;
            hit_idx_in = scan_idx_ff;
         end
         if (!idle_ff && !rd_active) begin
            idle_in     = 1'b1;
            idle_idx_in = scan_idx_ff;
         end
         if ((scan_idx_ff == '0) || (rd_age < best_age_ff)) begin
            best_idx_in = scan_idx_ff;
            best_age_in = rd_age;
            best_key_in = rd_key;
         end
         if (!scan_last) begin
            scan_idx_in = scan_idx_ff + VIDX_W'(1);
         end
      end

      if (cmd.apply) begin
         rsp_stamp_in = '0;
         if (on_ok) begin
            if (hit_ff) begin
               sel = hit_idx_ff;
               act = pva_pkg::ACT_RETRIG;
            end else if (idle_ff) begin
               sel      = idle_idx_ff;
               act      = pva_pkg::ACT_FREE;
               count_in = count_ff + CNT_W'(1);
            end else begin
               sel                 = best_idx_ff;
               act                 = pva_pkg::ACT_STOLEN;
               map_in[best_key_ff] = 1'b0;
            end
            note_count_in  = note_nxt;
            active_in[sel] = 1'b1;
            gate_in[sel]   = 1'b1;
            vkey_in[sel]   = key_ff;
            age_in[sel]    = note_nxt;
            map_in[key_ff] = 1'b1;
            rsp_stamp_in   = pva_pkg::STAMP_W'(note_nxt);
         end else if (off_ok) begin
            if (hit_ff) begin
               sel                 = hit_idx_ff;
               act                 = pva_pkg::ACT_GATE_OFF;
               gate_in[hit_idx_ff] = 1'b0;
            end
         end else if ((kind_ff == pva_pkg::KIND_DONE) && done_ok_ff && rd_active && !rd_gate) begin
            sel                    = scan_idx_ff;
            act                    = pva_pkg::ACT_FREED;
            active_in[scan_idx_ff] = 1'b0;
            vkey_in[scan_idx_ff]   = '0;
            map_in[rd_key]         = 1'b0;
            count_in               = count_ff - CNT_W'(1);
         end
         rsp_vidx_in   = pva_pkg::VIDX_OUT_W'(sel);
         rsp_action_in = act;
         rsp_count_in  = pva_pkg::COUNT_W'(count_in);
         rsp_map_in    = map_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         gate_ff       <= '0;
         note_count_ff <= '0;
         count_ff      <= '0;
         map_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_VOICES; i++) begin
            vkey_ff[i] <= '0;
            age_ff[i]  <= '0;
         end
      end else begin
         active_ff     <= active_in;
         gate_ff       <= gate_in;
         note_count_ff <= note_count_in;
         count_ff      <= count_in;
         map_ff        <= map_in;
         rsp_valid_ff  <= rsp_valid_in;
         vkey_ff       <= vkey_in;
         age_ff        <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      done_ok_ff    <= done_ok_in;
      scan_idx_ff   <= scan_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      idle_ff       <= idle_in;
      idle_idx_ff   <= idle_idx_in;
      best_idx_ff   <= best_idx_in;
      best_age_ff   <= best_age_in;
      best_key_ff   <= best_key_in;
      rsp_vidx_ff   <= rsp_vidx_in;
      rsp_action_ff <= rsp_action_in;
      rsp_stamp_ff  <= rsp_stamp_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_map_ff    <= rsp_map_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_voice_index    = rsp_vidx_ff;
   assign rsp_action         = rsp_action_ff;
   assign rsp_note_stamp     = rsp_stamp_ff;
   assign rsp_active_count   = rsp_count_ff;
   assign rsp_key_active_map = rsp_map_ff;

endmodule

`default_nettype wire
